// File: design/swmr_pkg.sv
// Shared constants, command/status structs for the sliding-window message rate meter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package swmr_pkg;

    // Window geometry.
    localparam int DEPTH   = 64;
    localparam int SLOT_W  = 6;
    localparam int FILL_W  = 7;

    // Field widths.
    localparam int STAMP_W = 63;
    localparam int SIZE_W  = 32;
    localparam int TOTAL_W = 38;
    localparam int AVG_W   = 40;
    localparam int RATE_W  = 28;
    localparam int GAP_W   = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT = 2'd1;
    localparam logic [GAP_W-1:0]     GAP_LIMIT_RST  = 32'd10000000;
    localparam logic [RATE_W-1:0]    RATE_LIMIT_RST = 28'd256000;

    // Item kinds.
    localparam logic KIND_ARRIVAL = 1'b0;
    localparam logic KIND_QUERY   = 1'b1;

    // Divider: 46-bit numerator covers size_total * 256, 63-bit divisor covers elapsed time.
    localparam int NUM_W     = 46;
    localparam int DEN_W     = 63;
    localparam int DIV_CNT_W = 6;

    // Rate numerator: count * 256e6 fits in 34 bits for a count up to 64.
    localparam int RNUM_W = 34;
    localparam logic [RNUM_W-1:0] RATE_SCALE = 34'd256000000;

    // Staleness: (now - newest) * rate > 512e6, with the time difference cut to 29 bits.
    localparam int STALE_D_W = 29;
    localparam int PROD_W    = STALE_D_W + RATE_W;
    localparam logic [STALE_D_W-1:0] STALE_SCALE = 29'd512000000;

    typedef struct packed {
        logic capture;    // latch the accepted item
        logic update;     // store an arrival into the window
        logic div_start;  // launch the average and rate divisions
        logic rate_fin;   // clamp the rate and register the average
        logic mul_fin;    // register the staleness product
        logic out_load;   // load the output register
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_stat;

endpackage

// File: design/swmr_div.sv
// Restoring divider, one quotient bit per cycle, fixed 46 steps.
// Depends on swmr_pkg for its widths.
`timescale 1ns / 1ps

module swmr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [swmr_pkg::NUM_W-1:0]  i_num,
    input  logic [swmr_pkg::DEN_W-1:0]  i_den,
    output logic                        o_busy,
    output logic [swmr_pkg::NUM_W-1:0]  o_quot
);

    logic                           r_busy;
    logic [swmr_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [swmr_pkg::DEN_W-1:0]     r_den;
    logic [swmr_pkg::DEN_W-1:0]     r_rem;
    logic [swmr_pkg::NUM_W-1:0]     r_quot;

    logic [swmr_pkg::DEN_W:0]       rem_sh;
    logic                           ge;
    logic [swmr_pkg::DEN_W:0]       rem_sub;

    assign rem_sh  = {r_rem, r_quot[swmr_pkg::NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= swmr_pkg::DIV_CNT_W'(swmr_pkg::NUM_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // The numerator shifts out of the top of r_quot while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= ge ? rem_sub[swmr_pkg::DEN_W-1:0] : rem_sh[swmr_pkg::DEN_W-1:0];
            r_quot <= {r_quot[swmr_pkg::NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// File: design/swmr_dp.sv
// Datapath: window rings, running totals, configuration registers, dividers,
// staleness multiply and the output register. Depends on swmr_pkg and swmr_div.
`timescale 1ns / 1ps

module swmr_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  swmr_pkg::t_cmd                   i_cmd,
    output swmr_pkg::t_stat                  o_stat,
    input  logic                             i_cfg_we,
    input  logic [swmr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [swmr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_kind,
    input  logic [swmr_pkg::STAMP_W-1:0]     i_time_us,
    input  logic [swmr_pkg::SIZE_W-1:0]      i_msg_bytes,
    output logic [swmr_pkg::STAMP_W-1:0]     o_newest_stamp,
    output logic [swmr_pkg::AVG_W-1:0]       o_avg_size_q8,
    output logic [swmr_pkg::RATE_W-1:0]      o_rate_q8,
    output logic                             o_stale,
    output logic [swmr_pkg::FILL_W-1:0]      o_entry_count
);

    // Configuration.
    logic [swmr_pkg::GAP_W-1:0]   r_gap_limit;
    logic [swmr_pkg::RATE_W-1:0]  r_rate_limit;

    // Captured item.
    logic                          r_kind;
    logic [swmr_pkg::STAMP_W-1:0]  r_time;
    logic [swmr_pkg::SIZE_W-1:0]   r_bytes;

    // Window state.
    logic [swmr_pkg::STAMP_W-1:0]  stamp_mem [swmr_pkg::DEPTH];
    logic [swmr_pkg::SIZE_W-1:0]   size_mem  [swmr_pkg::DEPTH];
    logic [swmr_pkg::STAMP_W-1:0]  r_rd_stamp;
    logic [swmr_pkg::SIZE_W-1:0]   r_rd_size;
    logic [swmr_pkg::SLOT_W-1:0]   r_slot;
    logic [swmr_pkg::FILL_W-1:0]   r_fill;
    logic [swmr_pkg::TOTAL_W-1:0]  r_total;
    logic [swmr_pkg::STAMP_W-1:0]  r_start;
    logic                          r_start_valid;
    logic [swmr_pkg::STAMP_W-1:0]  r_newest;
    logic [swmr_pkg::STAMP_W-1:0]  r_oldest;

    // Arithmetic results.
    logic                          r_rate_zero;
    logic                          r_rate_lim;
    logic [swmr_pkg::RATE_W-1:0]   r_rate;
    logic [swmr_pkg::AVG_W-1:0]    r_avg;
    logic [swmr_pkg::PROD_W-1:0]   r_prod;
    logic                          r_d_big;
    logic                          r_t_later;

    // Output register.
    logic [swmr_pkg::STAMP_W-1:0]  r_o_newest;
    logic [swmr_pkg::AVG_W-1:0]    r_o_avg;
    logic [swmr_pkg::RATE_W-1:0]   r_o_rate;
    logic                          r_o_stale;
    logic [swmr_pkg::FILL_W-1:0]   r_o_count;

    // Arrival update terms.
    logic [swmr_pkg::STAMP_W-1:0]  arr_diff;
    logic                          gap_clear;
    logic                          evict_start;
    logic [swmr_pkg::SLOT_W-1:0]   slot_e;
    logic [swmr_pkg::FILL_W-1:0]   fill_e;
    logic [swmr_pkg::TOTAL_W-1:0]  total_e;
    logic                          full_e;
    logic [swmr_pkg::TOTAL_W-1:0]  total_less;
    logic                          is_arrival_upd;

    // Rate terms.
    logic [swmr_pkg::FILL_W-1:0]   n_eff;
    logic [swmr_pkg::STAMP_W-1:0]  base;
    logic [swmr_pkg::STAMP_W-1:0]  elapsed;
    logic [swmr_pkg::RNUM_W-1:0]   rate_num;
    logic [swmr_pkg::NUM_W-1:0]    avg_num;
    logic [swmr_pkg::NUM_W-1:0]    avg_quot;
    logic [swmr_pkg::NUM_W-1:0]    rate_quot;
    logic                          avg_busy;
    logic                          rate_busy;

    // Staleness terms.
    logic [swmr_pkg::STAMP_W-1:0]  now_diff;
    logic                          n_stale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit  <= swmr_pkg::GAP_LIMIT_RST;
            r_rate_limit <= swmr_pkg::RATE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                swmr_pkg::CFG_GAP_LIMIT: begin
                    r_gap_limit <= i_cfg_data[swmr_pkg::GAP_W-1:0];
                end
                swmr_pkg::CFG_RATE_LIMIT: begin
                    r_rate_limit <= i_cfg_data[swmr_pkg::RATE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_time  <= i_time_us;
            r_bytes <= i_msg_bytes;
        end
    end

    // A silence longer than the gap limit empties the window before the new entry goes in.
    assign arr_diff       = r_time - r_newest;
    assign gap_clear      = (r_fill != '0) && (r_time > r_newest)
                            && (arr_diff > swmr_pkg::STAMP_W'(r_gap_limit));
    assign evict_start    = (r_fill != '0) && !gap_clear
                            && (r_fill >= swmr_pkg::FILL_W'(swmr_pkg::DEPTH));
    assign slot_e         = gap_clear ? '0 : r_slot;
    assign fill_e         = gap_clear ? '0 : r_fill;
    assign total_e        = gap_clear ? '0 : r_total;
    assign full_e         = fill_e >= swmr_pkg::FILL_W'(swmr_pkg::DEPTH);
    assign total_less     = full_e ? (total_e - swmr_pkg::TOTAL_W'(r_rd_size)) : total_e;
    assign is_arrival_upd = i_cmd.update && (r_kind == swmr_pkg::KIND_ARRIVAL);

    // The rings are read at the write slot every cycle; the entry about to be
    // overwritten is therefore ready by the time an arrival is stored.
    always_ff @(posedge i_clk) begin
        r_rd_stamp <= stamp_mem[r_slot];
        r_rd_size  <= size_mem[r_slot];
        if (is_arrival_upd) begin
            stamp_mem[slot_e] <= r_time;
            size_mem[slot_e]  <= r_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot        <= '0;
            r_fill        <= '0;
            r_total       <= '0;
            r_start       <= '0;
            r_start_valid <= 1'b0;
        end else if (is_arrival_upd) begin
            r_slot  <= (slot_e == swmr_pkg::SLOT_W'(swmr_pkg::DEPTH - 1)) ? '0 : slot_e + 1'b1;
            r_fill  <= full_e ? fill_e : fill_e + 1'b1;
            r_total <= total_less + swmr_pkg::TOTAL_W'(r_bytes);
            if (evict_start) begin
                r_start       <= r_rd_stamp;
                r_start_valid <= 1'b1;
            end else if (gap_clear) begin
                r_start_valid <= 1'b0;
            end
        end
    end

    // Until the first eviction after a clear, the oldest entry is the first one stored.
    always_ff @(posedge i_clk) begin
        if (is_arrival_upd) begin
            r_newest <= r_time;
            if (fill_e == '0) begin
                r_oldest <= r_time;
            end
        end
    end

    assign n_eff    = r_start_valid ? r_fill : r_fill - 1'b1;
    assign base     = r_start_valid ? r_start : r_oldest;
    assign elapsed  = r_newest - base;
    assign rate_num = swmr_pkg::RNUM_W'(n_eff) * swmr_pkg::RATE_SCALE;
    assign avg_num  = {r_total, 8'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rate_zero <= (r_fill < swmr_pkg::FILL_W'(2)) || (r_newest < base);
            r_rate_lim  <= elapsed == '0;
        end
    end

    swmr_div u_avg_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (avg_num),
        .i_den   (swmr_pkg::DEN_W'(r_fill)),
        .o_busy  (avg_busy),
        .o_quot  (avg_quot)
    );

    swmr_div u_rate_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (swmr_pkg::NUM_W'(rate_num)),
        .i_den   (elapsed),
        .o_busy  (rate_busy),
        .o_quot  (rate_quot)
    );

    assign o_stat.div_busy = avg_busy || rate_busy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rate_fin) begin
            if (r_rate_zero) begin
                r_rate <= '0;
            end else if (r_rate_lim
                         || (rate_quot > swmr_pkg::NUM_W'(r_rate_limit))) begin
                r_rate <= r_rate_limit;
            end else begin
                r_rate <= rate_quot[swmr_pkg::RATE_W-1:0];
            end
            r_avg <= (r_fill == '0) ? '0 : avg_quot[swmr_pkg::AVG_W-1:0];
        end
    end

    // Stale means (now - newest) > floor(512e6 / rate), which for integers is
    // the same as (now - newest) * rate > 512e6.
    assign now_diff = r_time - r_newest;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_fin) begin
            r_t_later <= r_time > r_newest;
            r_d_big   <= |now_diff[swmr_pkg::STAMP_W-1:swmr_pkg::STALE_D_W];
            r_prod    <= swmr_pkg::PROD_W'(now_diff[swmr_pkg::STALE_D_W-1:0])
                         * swmr_pkg::PROD_W'(r_rate);
        end
    end

    assign n_stale = (r_kind == swmr_pkg::KIND_QUERY) && (r_fill != '0) && (r_rate != '0)
                     && r_t_later
                     && (r_d_big || (r_prod > swmr_pkg::PROD_W'(swmr_pkg::STALE_SCALE)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_newest <= (r_fill == '0) ? '0 : r_newest;
            r_o_avg    <= r_avg;
            r_o_rate   <= r_rate;
            r_o_stale  <= n_stale;
            r_o_count  <= r_fill;
        end
    end

    assign o_newest_stamp = r_o_newest;
    assign o_avg_size_q8  = r_o_avg;
    assign o_rate_q8      = r_o_rate;
    assign o_stale        = r_o_stale;
    assign o_entry_count  = r_o_count;

endmodule

// File: design/swmr_ctrl.sv
// Controller state machine: sequences one item through store, divide,
// multiply and output load. Depends on swmr_pkg.
`timescale 1ns / 1ps

module swmr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  swmr_pkg::t_stat  i_stat,
    output swmr_pkg::t_cmd   o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_READ   = 8'b00000010,
        S_UPDATE = 8'b00000100,
        S_START  = 8'b00001000,
        S_DIV    = 8'b00010000,
        S_RATE   = 8'b00100000,
        S_MUL    = 8'b01000000,
        S_DONE   = 8'b10000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = S_START;
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_RATE;
                end
            end
            S_RATE: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd.capture   = accept;
    assign o_cmd.update    = r_state == S_UPDATE;
    assign o_cmd.div_start = r_state == S_START;
    assign o_cmd.rate_fin  = (r_state == S_DIV) && !i_stat.div_busy;
    assign o_cmd.mul_fin   = r_state == S_RATE;
    assign o_cmd.out_load  = (r_state == S_DONE) && out_free;

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

// File: design/sliding_window_message_rate_meter.sv
// Usage notes
// Input channel (i_in_valid / o_in_stall) carries one item: i_kind selects a
// message arrival (stamp and size) or a time query (current time in i_time_us).
// Each item gives exactly one result on the output channel (o_out_valid /
// i_out_stall): newest stamp, average size (Q8), rate in Hz (Q8), stale flag
// and entry count. Items move on edges where valid is high and stall is low.
// One item is in work at a time: a new item is taken only once the last
// result has been loaded into the output register. The two 46-step restoring
// dividers for average and rate run side by side.
// The output register lets the next item be accepted while a result waits.
// If the receiver stalls, the result holds and a finished next result waits in
// the datapath, keeping o_in_stall high until the output register frees up.
// Synchronous reset (i_rst_n low) empties the window, restores the gap limit
// to 10 s and the rate limit to 1000 Hz, and drops any pending result.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are registered;
// write only while no item is in work. Index 0 is the gap limit in us, index 1
// the rate clamp; other indexes are ignored.
// Depends on swmr_pkg, swmr_ctrl, swmr_dp and swmr_div.
`timescale 1ns / 1ps

module sliding_window_message_rate_meter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_kind,
    input  logic [swmr_pkg::STAMP_W-1:0]     i_time_us,
    input  logic [swmr_pkg::SIZE_W-1:0]      i_msg_bytes,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [swmr_pkg::STAMP_W-1:0]     o_newest_stamp,
    output logic [swmr_pkg::AVG_W-1:0]       o_avg_size_q8,
    output logic [swmr_pkg::RATE_W-1:0]      o_rate_q8,
    output logic                             o_stale,
    output logic [swmr_pkg::FILL_W-1:0]      o_entry_count,
    input  logic                             i_cfg_we,
    input  logic [swmr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [swmr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    swmr_pkg::t_cmd  cmd;
    swmr_pkg::t_stat stat;

    swmr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    swmr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_time_us      (i_time_us),
        .i_msg_bytes    (i_msg_bytes),
        .o_newest_stamp (o_newest_stamp),
        .o_avg_size_q8  (o_avg_size_q8),
        .o_rate_q8      (o_rate_q8),
        .o_stale        (o_stale),
        .o_entry_count  (o_entry_count)
    );

`ifndef SYNTHESIS
    // Only one item is in work: the input stalls right after an accept.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while an item is in work");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_count <= swmr_pkg::FILL_W'(swmr_pkg::DEPTH)))
        else $error("entry count above window depth");

    // A zero rate never reports stale.
    a_stale_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_rate_q8 == '0)) |-> !o_stale)
        else $error("stale flagged with zero rate");

    a_empty_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_entry_count == '0))
        |-> ((o_newest_stamp == '0) && (o_avg_size_q8 == '0) && (o_rate_q8 == '0)))
        else $error("empty window reports nonzero statistics");
`endif

endmodule
